FILE: sv/gcbd_pkg.sv
// shared types, constants and classification tables for the grapheme cluster boundary detector
package gcbd_pkg;

  localparam int CP_BITS  = 21;
  localparam int OUT_BITS = 32;

  typedef enum logic [3:0] {
    CLS_OTHER = 4'd0,
    CLS_CR    = 4'd1,
    CLS_LF    = 4'd2,
    CLS_CTRL  = 4'd3,
    CLS_ZWJ   = 4'd4,
    CLS_RI    = 4'd5,
    CLS_PICT  = 4'd6,
    CLS_EXT   = 4'd7,
    CLS_SPC   = 4'd8
  } cls_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_CR   = 2'd1,
    PH_RUN  = 2'd2,
    PH_ZWJ  = 2'd3
  } phase_t;

  typedef struct packed {
    cls_t cls;
    logic pict;
  } cls_info_t;

  localparam int EXT_N  = 5;
  localparam int SPC_N  = 140;
  localparam int PICT_N = 113;

  typedef logic [CP_BITS-1:0] cp_t;

  localparam cp_t EXT_LO [EXT_N] = '{21'h0300, 21'h1AB0, 21'h1DC0, 21'h20D0, 21'hFE20};
  localparam cp_t EXT_HI [EXT_N] = '{21'h036F, 21'h1AFF, 21'h1DFF, 21'h20FF, 21'hFE2F};

  localparam cp_t SPC_LO [SPC_N] = '{
    21'h0900, 21'h093B, 21'h093E, 21'h0949, 21'h094E, 21'h0982, 21'h09BE, 21'h09C7,
    21'h09CB, 21'h09D7, 21'h0A03, 21'h0A3E, 21'h0A83, 21'h0ABE, 21'h0AC9, 21'h0ACB,
    21'h0B02, 21'h0B3E, 21'h0B40, 21'h0B47, 21'h0B4B, 21'h0B57, 21'h0BBE, 21'h0BC1,
    21'h0BC6, 21'h0BCA, 21'h0BD7, 21'h0C01, 21'h0C41, 21'h0C82, 21'h0CBE, 21'h0CC0,
    21'h0CC7, 21'h0CCA, 21'h0CD5, 21'h0D02, 21'h0D3E, 21'h0D46, 21'h0D4A, 21'h0D57,
    21'h0DCF, 21'h0DD8, 21'h0DF2, 21'h0F3E, 21'h0F7F, 21'h102B, 21'h1031, 21'h1038,
    21'h103B, 21'h1056, 21'h1062, 21'h1067, 21'h1083, 21'h1087, 21'h108F, 21'h109A,
    21'h17B6, 21'h17BE, 21'h17C7, 21'h1923, 21'h1929, 21'h1930, 21'h1933, 21'h19B0,
    21'h19C8, 21'h1A19, 21'h1A55, 21'h1A57, 21'h1A6D, 21'h1B04, 21'h1B35, 21'h1B3B,
    21'h1B3D, 21'h1B43, 21'h1B82, 21'h1BA1, 21'h1BA6, 21'h1BAA, 21'h1BE7, 21'h1BEA,
    21'h1BEE, 21'h1BF2, 21'h1C24, 21'h1C34, 21'h1CE1, 21'h1CF2, 21'h1CF7, 21'hA823,
    21'hA827, 21'hA880, 21'hA8B4, 21'hA952, 21'hA983, 21'hA9B4, 21'hA9BA, 21'hA9BD,
    21'hAA2F, 21'hAA33, 21'hAA4D, 21'hAAEB, 21'hAAEE, 21'hAAF5, 21'hABE3, 21'hABE6,
    21'hABE9, 21'hABEC, 21'h11000, 21'h11002, 21'h11082, 21'h110B0, 21'h110B7,
    21'h1112C, 21'h11182, 21'h111B3, 21'h111BF, 21'h1122C, 21'h11232, 21'h11235,
    21'h112E0, 21'h11302, 21'h1133F, 21'h11341, 21'h11347, 21'h1134B, 21'h11362,
    21'h11435, 21'h11440, 21'h11443, 21'h0000, 21'h0000, 21'h0000, 21'h0000,
    21'h0000, 21'h0000, 21'h0000, 21'h0000, 21'h0000, 21'h0000, 21'h0000, 21'h0000
  };
  localparam cp_t SPC_HI [SPC_N] = '{
    21'h0903, 21'h093C, 21'h0940, 21'h094C, 21'h094F, 21'h0983, 21'h09C0, 21'h09C8,
    21'h09CC, 21'h09D7, 21'h0A03, 21'h0A40, 21'h0A83, 21'h0AC0, 21'h0AC9, 21'h0ACC,
    21'h0B03, 21'h0B3E, 21'h0B40, 21'h0B48, 21'h0B4C, 21'h0B57, 21'h0BBF, 21'h0BC2,
    21'h0BC8, 21'h0BCC, 21'h0BD7, 21'h0C03, 21'h0C44, 21'h0C83, 21'h0CBE, 21'h0CC4,
    21'h0CC8, 21'h0CCB, 21'h0CD6, 21'h0D03, 21'h0D40, 21'h0D48, 21'h0D4C, 21'h0D57,
    21'h0DD1, 21'h0DDF, 21'h0DF3, 21'h0F3F, 21'h0F7F, 21'h102C, 21'h1031, 21'h1038,
    21'h103C, 21'h1057, 21'h1062, 21'h1068, 21'h1084, 21'h108C, 21'h108F, 21'h109C,
    21'h17B6, 21'h17C5, 21'h17C8, 21'h1926, 21'h192B, 21'h1931, 21'h1938, 21'h19C0,
    21'h19C9, 21'h1A1A, 21'h1A55, 21'h1A57, 21'h1A72, 21'h1B04, 21'h1B35, 21'h1B3B,
    21'h1B41, 21'h1B44, 21'h1B82, 21'h1BA1, 21'h1BA7, 21'h1BAA, 21'h1BE7, 21'h1BEC,
    21'h1BEE, 21'h1BF3, 21'h1C2B, 21'h1C35, 21'h1CE1, 21'h1CF3, 21'h1CF7, 21'hA824,
    21'hA827, 21'hA881, 21'hA8C3, 21'hA953, 21'hA983, 21'hA9B5, 21'hA9BB, 21'hA9C0,
    21'hAA30, 21'hAA34, 21'hAA4D, 21'hAAEB, 21'hAAEF, 21'hAAF5, 21'hABE4, 21'hABE7,
    21'hABEA, 21'hABEC, 21'h11000, 21'h11002, 21'h11082, 21'h110B2, 21'h110B8,
    21'h1112C, 21'h11182, 21'h111B5, 21'h111C0, 21'h1122E, 21'h11233, 21'h11235,
    21'h112E2, 21'h11303, 21'h1133F, 21'h11344, 21'h11348, 21'h1134D, 21'h11363,
    21'h11437, 21'h11441, 21'h11445, 21'h0000, 21'h0000, 21'h0000, 21'h0000,
    21'h0000, 21'h0000, 21'h0000, 21'h0000, 21'h0000, 21'h0000, 21'h0000, 21'h0000
  };

  localparam cp_t PICT_LO [PICT_N] = '{
    21'h00A9, 21'h00AE, 21'h203C, 21'h2049, 21'h20E3, 21'h2122, 21'h2139, 21'h2194,
    21'h21A9, 21'h231A, 21'h2328, 21'h23CF, 21'h23E9, 21'h23F8, 21'h24C2, 21'h25AA,
    21'h25B6, 21'h25C0, 21'h25FB, 21'h2600, 21'h260E, 21'h2611, 21'h2614, 21'h2618,
    21'h261D, 21'h2620, 21'h2622, 21'h2626, 21'h262A, 21'h262E, 21'h2638, 21'h2640,
    21'h2642, 21'h2648, 21'h265F, 21'h2663, 21'h2665, 21'h2668, 21'h267B, 21'h267E,
    21'h2692, 21'h2699, 21'h269B, 21'h26A0, 21'h26AA, 21'h26B0, 21'h26BD, 21'h26C4,
    21'h26CE, 21'h26D1, 21'h26D3, 21'h26E9, 21'h26F0, 21'h26F7, 21'h26FD, 21'h2702,
    21'h2705, 21'h2708, 21'h270F, 21'h2712, 21'h2714, 21'h2716, 21'h271D, 21'h2721,
    21'h2728, 21'h2733, 21'h2744, 21'h2747, 21'h274C, 21'h274E, 21'h2753, 21'h2757,
    21'h2763, 21'h2795, 21'h27A1, 21'h27B0, 21'h27BF, 21'h2934, 21'h2B05, 21'h2B1B,
    21'h2B50, 21'h2B55, 21'h3030, 21'h303D, 21'h3297, 21'h3299, 21'h1F000, 21'h1F0CF,
    21'h1F170, 21'h1F17E, 21'h1F18E, 21'h1F191, 21'h1F1E0, 21'h1F201, 21'h1F21A,
    21'h1F22F, 21'h1F232, 21'h1F250, 21'h1F300, 21'h0000, 21'h0000, 21'h0000, 21'h0000,
    21'h0000, 21'h0000, 21'h0000, 21'h0000, 21'h0000, 21'h0000, 21'h0000, 21'h0000,
    21'h0000, 21'h0000
  };
  localparam cp_t PICT_HI [PICT_N] = '{
    21'h00A9, 21'h00AE, 21'h203C, 21'h2049, 21'h20E3, 21'h2122, 21'h2139, 21'h2199,
    21'h21AA, 21'h231B, 21'h2328, 21'h23CF, 21'h23F3, 21'h23FA, 21'h24C2, 21'h25AB,
    21'h25B6, 21'h25C0, 21'h25FE, 21'h2604, 21'h260E, 21'h2611, 21'h2615, 21'h2618,
    21'h261D, 21'h2620, 21'h2623, 21'h2626, 21'h262A, 21'h262F, 21'h263A, 21'h2640,
    21'h2642, 21'h2653, 21'h2660, 21'h2663, 21'h2666, 21'h2668, 21'h267B, 21'h267F,
    21'h2697, 21'h2699, 21'h269C, 21'h26A1, 21'h26AB, 21'h26B1, 21'h26BE, 21'h26C5,
    21'h26CF, 21'h26D1, 21'h26D4, 21'h26EA, 21'h26F5, 21'h26FA, 21'h26FD, 21'h2702,
    21'h2705, 21'h270D, 21'h270F, 21'h2712, 21'h2714, 21'h2716, 21'h271D, 21'h2721,
    21'h2728, 21'h2734, 21'h2744, 21'h2747, 21'h274C, 21'h274E, 21'h2755, 21'h2757,
    21'h2764, 21'h2797, 21'h27A1, 21'h27B0, 21'h27BF, 21'h2935, 21'h2B07, 21'h2B1C,
    21'h2B50, 21'h2B55, 21'h3030, 21'h303D, 21'h3297, 21'h3299, 21'h1F02F, 21'h1F0CF,
    21'h1F171, 21'h1F17F, 21'h1F18E, 21'h1F19A, 21'h1F1FF, 21'h1F202, 21'h1F21A,
    21'h1F22F, 21'h1F23A, 21'h1F251, 21'h1FAFF, 21'h0000, 21'h0000, 21'h0000, 21'h0000,
    21'h0000, 21'h0000, 21'h0000, 21'h0000, 21'h0000, 21'h0000, 21'h0000, 21'h0000,
    21'h0000, 21'h0000
  };

  // unused tail entries hold 0..0; they are masked by the used counts
  localparam int SPC_USED  = 128;
  localparam int PICT_USED = 99;

  localparam cp_t CP_CR  = 21'h0000D;
  localparam cp_t CP_LF  = 21'h0000A;
  localparam cp_t CP_SP  = 21'h00020;
  localparam cp_t CP_DEL = 21'h0007F;
  localparam cp_t CP_NBS = 21'h000A0;
  localparam cp_t CP_ZWJ = 21'h0200D;
  localparam cp_t CP_RI0 = 21'h1F1E6;
  localparam cp_t CP_RI1 = 21'h1F1FF;

endpackage

FILE: sv/gcbd_if.sv
// valid/ready stream interface used by the detector channels
interface gcbd_if #(
  parameter int W = 22
) (
  input logic clk
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: sv/gcbd_classify.sv
// codepoint classifier: parallel range compares against the fixed tables
module gcbd_classify
  import gcbd_pkg::*;
(
  input  logic [CP_BITS-1:0] cp,
  output cls_info_t          info
);
  logic ext_hit;
  logic spc_hit;
  logic pict_hit;

  always_comb begin
    ext_hit  = 1'b0;
    spc_hit  = 1'b0;
    pict_hit = 1'b0;
    for (int i = 0; i < EXT_N; i++) begin
      if (cp >= EXT_LO[i] && cp <= EXT_HI[i]) ext_hit = 1'b1;
    end
    for (int i = 0; i < SPC_USED; i++) begin
      if (cp >= SPC_LO[i] && cp <= SPC_HI[i]) spc_hit = 1'b1;
    end
    for (int i = 0; i < PICT_USED; i++) begin
      if (cp >= PICT_LO[i] && cp <= PICT_HI[i]) pict_hit = 1'b1;
    end
  end

  always_comb begin
    info.pict = pict_hit;
    if (cp == CP_CR) begin
      info.cls = CLS_CR;
    end else if (cp == CP_LF) begin
      info.cls = CLS_LF;
    end else if (cp < CP_SP || (cp >= CP_DEL && cp < CP_NBS)) begin
      info.cls = CLS_CTRL;
    end else if (cp == CP_ZWJ) begin
      info.cls = CLS_ZWJ;
    end else if (cp >= CP_RI0 && cp <= CP_RI1) begin
      info.cls = CLS_RI;
    end else if (pict_hit) begin
      info.cls = CLS_PICT;
    end else if (ext_hit) begin
      info.cls = CLS_EXT;
    end else if (spc_hit) begin
      info.cls = CLS_SPC;
    end else begin
      info.cls = CLS_OTHER;
    end
  end
endmodule

FILE: sv/grapheme_cluster_boundary_detector.sv
// top level of the grapheme cluster boundary detector
// usage:
//   in channel carries one codepoint (21 bits) and a last flag per transfer.
//   out channel carries boundary_before, char_class and cluster_count,
//   one result transfer for every input transfer, in order.
// pipeline: an input register holds the codepoint for classification; the
//   boundary rules and the count update feed the result register.
// throughput: one codepoint per cycle while out_ready stays high; the phase,
//   regional flag and count registers are updated in the same cycle the
//   classified item moves to the result register, which bounds the rate.
// stall: when out_ready is low the result register holds and the input
//   register fills; in_ready drops only once both hold an item.
// reset: rst_n low clears both stages and the state (phase idle, regional
//   flag zero, count zero). after a codepoint marked last the state returns
//   to that same reset value.
// COUNT_BITS sets the internal counter width; the port carries its low
//   32 bits, zero-extended when narrower.
module grapheme_cluster_boundary_detector
  import gcbd_pkg::*;
#(
  parameter int COUNT_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CP_BITS-1:0]   in_codepoint,
  input  logic                 in_last,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_boundary_before,
  output logic [3:0]           out_char_class,
  output logic [OUT_BITS-1:0]  out_cluster_count
);
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  logic               s1_valid_r;
  logic [CP_BITS-1:0] s1_cp_r;
  logic               s1_last_r;
  logic               s1_adv;
  cls_info_t          info;

  phase_t                phase_r, phase_nxt;
  logic                  ri_r, ri_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                  join_c;
  logic [OUT_BITS-1:0]   cnt_out;

  assign s1_adv   = s1_valid_r && (!out_valid || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_cp_r   <= in_codepoint;
      s1_last_r <= in_last;
    end
  end

  gcbd_classify u_cls (
    .cp   (s1_cp_r),
    .info (info)
  );

  always_comb begin
    join_c    = 1'b0;
    phase_nxt = PH_IDLE;
    case (phase_r)
      PH_CR: begin
        if (info.cls == CLS_LF) join_c = 1'b1;
      end
      PH_RUN, PH_ZWJ: begin
        if (phase_r == PH_ZWJ && info.pict) begin
          join_c = 1'b1; phase_nxt = PH_RUN;
        end else if (info.cls == CLS_EXT || info.cls == CLS_SPC) begin
          join_c = 1'b1; phase_nxt = PH_RUN;
        end else if (info.cls == CLS_ZWJ) begin
          join_c = 1'b1; phase_nxt = PH_ZWJ;
        end else if (ri_r && info.cls == CLS_RI) begin
          join_c = 1'b1; phase_nxt = PH_IDLE;
        end
      end
      default: ;
    endcase
    cnt_nxt = cnt_r;
    ri_nxt  = ri_r;
    if (!join_c) begin
      if (cnt_r != CMAX) cnt_nxt = cnt_r + 1'b1;
      ri_nxt = (info.cls == CLS_RI);
      if (info.cls == CLS_CR) phase_nxt = PH_CR;
      else if (info.cls == CLS_LF || info.cls == CLS_CTRL) phase_nxt = PH_IDLE;
      else phase_nxt = PH_RUN;
    end
  end

  generate
    if (COUNT_BITS >= OUT_BITS) begin : g_wide
      assign cnt_out = cnt_nxt[OUT_BITS-1:0];
    end else begin : g_narrow
      assign cnt_out = {{(OUT_BITS-COUNT_BITS){1'b0}}, cnt_nxt};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
      phase_r   <= PH_IDLE;
      ri_r      <= 1'b0;
      cnt_r     <= '0;
    end else begin
      if (s1_adv) begin
        out_valid <= 1'b1;
        if (s1_last_r) begin
          phase_r <= PH_IDLE;
          ri_r    <= 1'b0;
          cnt_r   <= '0;
        end else begin
          phase_r <= phase_nxt;
          ri_r    <= ri_nxt;
          cnt_r   <= cnt_nxt;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (s1_adv) begin
      out_boundary_before <= !join_c;
      out_char_class      <= info.cls;
      out_cluster_count   <= cnt_out;
    end
  end

`ifndef SYNTH
  a_first_boundary: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && cnt_r == '0) |-> !join_c)
    else $error("first item of a string not a boundary");
  a_cr_state: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && !s1_last_r && info.cls == CLS_CR) |=> phase_r == PH_CR)
    else $error("cr did not enter cr phase");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && !s1_last_r && join_c) |=> cnt_r == $past(cnt_r))
    else $error("count moved on a joined item");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !s1_adv)
    else $error("result overwritten while stalled");
`endif
endmodule

FILE: tb/sv/tb_grapheme_cluster_boundary_detector.sv
// self-checking testbench for the grapheme cluster boundary detector
module tb_grapheme_cluster_boundary_detector;
  import gcbd_pkg::*;

  typedef struct {
    cp_t  cp;
    logic last;
  } char_item_t;

  typedef struct {
    logic        boundary;
    cls_t        cls;
    logic [31:0] count;
  } seg_result_t;

  localparam int CLS_PICK_N = 9;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  gcbd_if #(.W(22)) in_ch (.clk(clk));
  gcbd_if #(.W(37)) out_ch (.clk(clk));

  grapheme_cluster_boundary_detector uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_ch.valid),
    .in_ready            (in_ch.ready),
    .in_codepoint        (in_ch.data[20:0]),
    .in_last             (in_ch.data[21]),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .out_boundary_before (out_ch.data[36]),
    .out_char_class      (out_ch.data[35:32]),
    .out_cluster_count   (out_ch.data[31:0])
  );

  char_item_t  chars_to_send[$];
  seg_result_t expected_segs[$];
  int          errors = 0;
  bit          quiet = 1'b0;
  int          in_gap = 0;
  int          out_gap = 0;

  phase_t      seg_phase;
  logic        seg_ri_start;
  logic [31:0] seg_count;

  function automatic logic is_pict_cp(cp_t cp);
    for (int i = 0; i < PICT_USED; i++)
      if (cp >= PICT_LO[i] && cp <= PICT_HI[i]) return 1'b1;
    return 1'b0;
  endfunction

  function automatic cls_t char_class_of(cp_t cp);
    logic hit;
    hit = 1'b0;
    if (cp == 21'h0000D) return CLS_CR;
    if (cp == 21'h0000A) return CLS_LF;
    if (cp < 21'h20 || (cp >= 21'h7F && cp < 21'hA0)) return CLS_CTRL;
    if (cp == 21'h200D) return CLS_ZWJ;
    if (cp >= 21'h1F1E6 && cp <= 21'h1F1FF) return CLS_RI;
    if (is_pict_cp(cp)) return CLS_PICT;
    for (int i = 0; i < EXT_N; i++)
      if (cp >= EXT_LO[i] && cp <= EXT_HI[i]) hit = 1'b1;
    if (hit) return CLS_EXT;
    for (int i = 0; i < SPC_USED; i++)
      if (cp >= SPC_LO[i] && cp <= SPC_HI[i]) hit = 1'b1;
    if (hit) return CLS_SPC;
    return CLS_OTHER;
  endfunction

  task automatic segment_char(char_item_t c);
    cls_t        cls;
    logic        joined;
    phase_t      nxt;
    seg_result_t r;
    cls = char_class_of(c.cp);
    joined = 1'b0;
    nxt = PH_IDLE;
    if (seg_phase == PH_CR) begin
      if (cls == CLS_LF) joined = 1'b1;
    end else if (seg_phase == PH_RUN || seg_phase == PH_ZWJ) begin
      if (seg_phase == PH_ZWJ && is_pict_cp(c.cp)) begin
        joined = 1'b1; nxt = PH_RUN;
      end else if (cls == CLS_EXT || cls == CLS_SPC) begin
        joined = 1'b1; nxt = PH_RUN;
      end else if (cls == CLS_ZWJ) begin
        joined = 1'b1; nxt = PH_ZWJ;
      end else if (seg_ri_start && cls == CLS_RI) begin
        joined = 1'b1; nxt = PH_IDLE;
      end
    end
    if (!joined) begin
      if (seg_count != 32'hFFFF_FFFF) seg_count = seg_count + 1;
      seg_ri_start = (cls == CLS_RI);
      if (cls == CLS_CR) nxt = PH_CR;
      else if (cls == CLS_LF || cls == CLS_CTRL) nxt = PH_IDLE;
      else nxt = PH_RUN;
    end
    seg_phase = nxt;
    r.boundary = !joined;
    r.cls = cls;
    r.count = seg_count;
    expected_segs.push_back(r);
    if (c.last) begin
      seg_phase = PH_IDLE;
      seg_ri_start = 1'b0;
      seg_count = '0;
    end
  endtask

  // codepoint of a chosen class, random inside its ranges
  function automatic cp_t pick_cp(int k);
    int i;
    case (k)
      0: return cp_t'($urandom_range(21'h41, 21'h7E));
      1: return 21'h0000D;
      2: return 21'h0000A;
      3: return cp_t'($urandom_range(0, 21'h1F));
      4: return 21'h200D;
      5: return cp_t'($urandom_range(21'h1F1E6, 21'h1F1FF));
      6: begin
        i = $urandom_range(0, PICT_USED - 1);
        return cp_t'($urandom_range(PICT_LO[i], PICT_HI[i]));
      end
      7: begin
        i = $urandom_range(0, EXT_N - 1);
        return cp_t'($urandom_range(EXT_LO[i], EXT_HI[i]));
      end
      8: begin
        i = $urandom_range(0, SPC_USED - 1);
        return cp_t'($urandom_range(SPC_LO[i], SPC_HI[i]));
      end
      default: return cp_t'($urandom_range(0, 21'h1FFFFF));
    endcase
  endfunction

  task automatic add_char(cp_t cp, logic last);
    char_item_t c;
    c.cp = cp;
    c.last = last;
    chars_to_send.push_back(c);
  endtask

  // one well-formed cluster with random content
  task automatic add_cluster(ref int n);
    int start_k;
    int tail;
    int k;
    start_k = $urandom_range(0, 9);
    case (start_k)
      0, 1: add_char(pick_cp(0), 1'b0);
      2: begin add_char(pick_cp(1), 1'b0); add_char(pick_cp(2), 1'b0); n++; end
      3: add_char(pick_cp($urandom_range(1, 3)), 1'b0);
      4, 5: add_char(pick_cp(5), 1'b0);
      6, 7: add_char(pick_cp(6), 1'b0);
      8: add_char(pick_cp(4), 1'b0);
      default: add_char(pick_cp(9), 1'b0);
    endcase
    n++;
    tail = $urandom_range(0, 4);
    for (int t = 0; t < tail; t++) begin
      k = $urandom_range(0, 3);
      if (k == 0) begin
        add_char(pick_cp(4), 1'b0);
        n++;
        if ($urandom_range(0, 2) != 0) begin add_char(pick_cp(6), 1'b0); n++; end
      end else begin
        add_char(pick_cp(k == 1 ? 7 : 8), 1'b0);
        n++;
      end
    end
    if ((start_k == 4 || start_k == 5) && $urandom_range(0, 3) != 0) begin
      add_char(pick_cp(5), 1'b0);
      n++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (chars_to_send.size() > 0) begin
        if (!quiet && $urandom_range(0, 7) == 0) begin
          in_gap <= $urandom_range(1, 8) - 1;
          in_ch.valid <= 1'b0;
        end else begin
          in_ch.valid <= 1'b1;
          in_ch.data <= {chars_to_send[0].last, chars_to_send[0].cp};
          void'(chars_to_send.pop_front());
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result side stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_gap <= $urandom_range(1, 8) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    char_item_t  c;
    seg_result_t e;
    if (!rst_n) begin
      seg_phase <= PH_IDLE;
      seg_ri_start <= 1'b0;
      seg_count <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        c.cp = in_ch.data[20:0];
        c.last = in_ch.data[21];
        segment_char(c);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_segs.size() == 0) begin
          $display("%0t: unexpected result transfer %h", $time, out_ch.data);
          errors++;
        end else begin
          e = expected_segs.pop_front();
          if (out_ch.data[36] !== e.boundary) begin
            $display("%0t: boundary_before expected %0b actual %0b",
                     $time, e.boundary, out_ch.data[36]);
            errors++;
          end
          if (out_ch.data[35:32] !== e.cls) begin
            $display("%0t: char_class expected %0d actual %0d",
                     $time, e.cls, out_ch.data[35:32]);
            errors++;
          end
          if (out_ch.data[31:0] !== e.count) begin
            $display("%0t: cluster_count expected %0d actual %0d",
                     $time, e.count, out_ch.data[31:0]);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    int n;
    n = 0;
    // directed: crlf, lone cr and lf, control edges
    add_char(21'h0000D, 1'b0); add_char(21'h0000A, 1'b0);
    add_char(21'h0000D, 1'b0); add_char(21'h00041, 1'b0);
    add_char(21'h0000A, 1'b0); add_char(21'h00000, 1'b0);
    add_char(21'h0001F, 1'b0); add_char(21'h0007F, 1'b0);
    add_char(21'h0009F, 1'b0); add_char(21'h000A0, 1'b0);
    // zwj joins pictographic, zwj between pictographics
    add_char(21'h1F600, 1'b0); add_char(21'h0200D, 1'b0);
    add_char(21'h1F468, 1'b0); add_char(21'h0200D, 1'b0);
    add_char(21'h1F469, 1'b0);
    // regional pairs, ri after zwj, 0x20e3 pictographic
    add_char(21'h1F1E6, 1'b0); add_char(21'h00301, 1'b0);
    add_char(21'h1F1FF, 1'b0); add_char(21'h1F1E6, 1'b0);
    add_char(21'h00041, 1'b0); add_char(21'h0200D, 1'b0);
    add_char(21'h1F1E7, 1'b0); add_char(21'h020E3, 1'b0);
    // out of range, surrogate, max scalar
    add_char(21'h1FFFFF, 1'b0); add_char(21'h0D800, 1'b0);
    add_char(21'h10FFFF, 1'b1);
    while (n < 950) begin
      if ($urandom_range(0, 9) < 8) begin
        add_cluster(n);
      end else begin
        add_char(pick_cp($urandom_range(0, CLS_PICK_N)), 1'b0);
        n++;
      end
      if ($urandom_range(0, 11) == 0) chars_to_send[$].last = 1'b1;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    wait (chars_to_send.size() < 150);
    quiet = 1'b1;
    wait (chars_to_send.size() == 0 && expected_segs.size() == 0);
    repeat (10) @(posedge clk);
    if (errors == 0 && expected_segs.size() == 0)
      $display("tb_grapheme_cluster_boundary_detector passed");
    else
      $display("tb_grapheme_cluster_boundary_detector failed");
    $finish;
  end

  initial begin
    #5000000;
    $display("tb_grapheme_cluster_boundary_detector failed");
    $finish;
  end

endmodule
